// ===== sv/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants for the servo status packet deframer
// Op codes, status codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] ST_BUSY       = 3'd0;
    localparam logic [2:0] ST_OK         = 3'd1;
    localparam logic [2:0] ST_BAD_HEADER = 3'd2;
    localparam logic [2:0] ST_TOO_LONG   = 3'd3;
    localparam logic [2:0] ST_BAD_SUM    = 3'd4;
    localparam logic [2:0] ST_TIMEOUT    = 3'd5;

    localparam logic CFG_MAX_LEN = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [7:0]  HDR_BYTE       = 8'hFF;
    localparam logic [8:0]  HDR_LEN        = 9'd4;
    localparam logic [8:0]  LEN_POS        = 9'd3;
    localparam logic [8:0]  MAX_LEN_RESET  = 9'd259;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
    localparam logic [8:0]  COUNT_MAX      = 9'h1FF;
    localparam logic [15:0] TICK_MAX       = 16'hFFFF;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [8:0] byte_pos;
        logic       done_res;
        logic [2:0] status;
        logic [8:0] frame_len;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } push_t;

endpackage

// ===== sv/servo_status_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// servo_status_packet_deframer_unit: servo bus status packet receiver
// Checks header, length and checksum of a reply frame byte by byte.
// ----------------------------------------------------------------------------
// A start request arms the receiver; each byte request while armed returns one
// result (echo, position, status, frame length) and tick requests return a
// result only on timeout. One request is accepted per cycle until the result
// queue (QUEUE_DEPTH entries) fills, also while the output stalls; a result
// passes through the result queue and then the output register.
// Configuration writes are accepted every cycle.
module servo_status_packet_deframer_unit #(
    parameter int QUEUE_DEPTH = ssd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [8:0]  byte_pos,
    output logic        done_res,
    output logic [2:0]  status,
    output logic [8:0]  frame_len,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    ssd_pkg::push_t push;
    ssd_pkg::res_t  head;
    ssd_pkg::res_t  res;
    logic           q_full;
    logic           q_empty;
    logic           pop;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;

    ssd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_valid && in_ready),
        .op        (op),
        .rx_byte   (rx_byte),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    ssd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (q_full),
        .empty (q_empty)
    );

    ssd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign out_byte  = res.out_byte;
    assign byte_pos  = res.byte_pos;
    assign done_res  = res.done_res;
    assign status    = res.status;
    assign frame_len = res.frame_len;

`ifndef NO_ASSERTIONS
    // a result is never produced into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_full)
        else $error("result pushed into full queue");

    // only a final result carries an end status
    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (done_res == (status != ssd_pkg::ST_BUSY)))
        else $error("done flag and status disagree");

    // a good frame ends on its last byte
    a_ok_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ssd_pkg::ST_OK) |->
        (({1'b0, byte_pos} + 10'd1) == {1'b0, frame_len}))
        else $error("ok status away from frame end");
`endif

endmodule

// ===== sv/ssd_front.sv =====
// ----------------------------------------------------------------------------
// ssd_front: request classification and frame tracking
// Decodes each accepted request, updates the reception state and builds
// the result record, if any, for the queue.
// ----------------------------------------------------------------------------
module ssd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [1:0]          op,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_fire,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    output ssd_pkg::push_t      push
);

    logic [8:0]  max_len_reg;
    logic [15:0] timeout_reg;
    logic        armed_reg, armed_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic        header_good_reg, header_good_next;
    logic [8:0]  total_len_reg, total_len_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] ticks_reg, ticks_next;

    logic [8:0]  pos;
    logic [8:0]  len_cand;
    logic [8:0]  cur_len;
    logic        is_last;
    logic [15:0] ticks_inc;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_len_reg <= ssd_pkg::MAX_LEN_RESET;
            timeout_reg <= ssd_pkg::TIMEOUT_RESET;
        end
        else if (cfg_fire) begin
            case (cfg_index)
                ssd_pkg::CFG_MAX_LEN: max_len_reg <= cfg_data[8:0];
                ssd_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pos       = byte_count_reg;
    assign len_cand  = ssd_pkg::HDR_LEN + {1'b0, rx_byte};
    assign cur_len   = (pos == ssd_pkg::LEN_POS) ? len_cand : total_len_reg;
    // last byte of the frame: only from the length byte onward
    assign is_last   = (pos >= ssd_pkg::LEN_POS) &&
                       (({1'b0, pos} + 10'd1) == {1'b0, cur_len});
    assign ticks_inc = (ticks_reg != ssd_pkg::TICK_MAX) ? ticks_reg + 16'd1 : ticks_reg;

    always_comb begin
        armed_next       = armed_reg;
        byte_count_next  = byte_count_reg;
        header_good_next = header_good_reg;
        total_len_next   = total_len_reg;
        sum_next         = sum_reg;
        ticks_next       = ticks_reg;
        push             = '0;

        if (in_fire) begin
            case (op)
                ssd_pkg::OP_START: begin
                    armed_next       = 1'b1;
                    byte_count_next  = '0;
                    header_good_next = 1'b1;
                    total_len_next   = '0;
                    sum_next         = '0;
                    ticks_next       = '0;
                end
                ssd_pkg::OP_BYTE: begin
                    if (armed_reg) begin
                        if (byte_count_reg != ssd_pkg::COUNT_MAX)
                            byte_count_next = byte_count_reg + 9'd1;
                        push.valid        = 1'b1;
                        push.res.out_byte = rx_byte;
                        push.res.byte_pos = pos;
                        push.res.status   = ssd_pkg::ST_BUSY;
                        if (pos < 9'd2) begin
                            if (rx_byte != ssd_pkg::HDR_BYTE)
                                header_good_next = 1'b0;
                        end
                        else if (pos == ssd_pkg::LEN_POS && !header_good_reg) begin
                            push.res.done_res = 1'b1;
                            push.res.status   = ssd_pkg::ST_BAD_HEADER;
                        end
                        else begin
                            total_len_next     = cur_len;
                            push.res.frame_len = cur_len;
                            if (pos == ssd_pkg::LEN_POS && len_cand > max_len_reg) begin
                                push.res.done_res = 1'b1;
                                push.res.status   = ssd_pkg::ST_TOO_LONG;
                            end
                            else if (is_last) begin
                                push.res.done_res = 1'b1;
                                push.res.status   = (rx_byte == ~sum_reg) ?
                                                    ssd_pkg::ST_OK : ssd_pkg::ST_BAD_SUM;
                            end
                            else begin
                                sum_next = sum_reg + rx_byte;
                            end
                        end
                        if (push.res.done_res)
                            armed_next = 1'b0;
                    end
                end
                ssd_pkg::OP_TICK: begin
                    if (armed_reg) begin
                        ticks_next = ticks_inc;
                        if (ticks_inc > timeout_reg) begin
                            armed_next         = 1'b0;
                            push.valid         = 1'b1;
                            push.res.byte_pos  = byte_count_reg;
                            push.res.done_res  = 1'b1;
                            push.res.status    = ssd_pkg::ST_TIMEOUT;
                            push.res.frame_len = total_len_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            armed_reg       <= 1'b0;
            byte_count_reg  <= '0;
            header_good_reg <= 1'b1;
            total_len_reg   <= '0;
            sum_reg         <= '0;
            ticks_reg       <= '0;
        end
        else begin
            armed_reg       <= armed_next;
            byte_count_reg  <= byte_count_next;
            header_good_reg <= header_good_next;
            total_len_reg   <= total_len_next;
            sum_reg         <= sum_next;
            ticks_reg       <= ticks_next;
        end
    end

endmodule

// ===== sv/ssd_queue.sv =====
// ----------------------------------------------------------------------------
// ssd_queue: result queue between front and back
// Small register FIFO; full and empty flags steer both sides.
// ----------------------------------------------------------------------------
module ssd_queue #(
    parameter int DEPTH = ssd_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ssd_pkg::push_t      push,
    input  logic                pop,
    output ssd_pkg::res_t       head,
    output logic                full,
    output logic                empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    ssd_pkg::res_t   mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk) begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.res;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/ssd_back.sv =====
// ----------------------------------------------------------------------------
// ssd_back: result delivery
// Output register fed from the queue; reloads, if the queue holds a result,
// whenever the held result is taken or the register is empty.
// ----------------------------------------------------------------------------
module ssd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ssd_pkg::res_t       head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output ssd_pkg::res_t       res
);

    logic          valid_reg;
    ssd_pkg::res_t res_reg;

    assign pop       = !empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        if (pop)
            res_reg <= head;
    end

endmodule
